/* rtl/core/rgb_to_hsv_convert_core_assert.svh */
// Assertion macros shared by the rgb_to_hsv_convert_core checker.
`ifndef RGB_TO_HSV_CONVERT_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_CORE_ASSERT_SVH

// clocked assertion, off while in reset
`define RGBHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches reset
`define RGBHSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rgbhsv_pkg.sv */
// Shared constants for the RGB to HSV conversion core.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS_DEF     = 16;

endpackage

/* rtl/core/rgbhsv_front.sv */
// Front stage: max/min, delta, sextant offset and divider set-up for one pixel.
`timescale 1ns / 1ps

module rgbhsv_front
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [CHANNEL_BITS-1:0]   up_red,
  input  logic [CHANNEL_BITS-1:0]   up_green,
  input  logic [CHANNEL_BITS-1:0]   up_blue,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [CHANNEL_BITS+2:0]   dn_hrem,
  output logic [CHANNEL_BITS+2:0]   dn_turn,
  output logic [CHANNEL_BITS-1:0]   dn_srem,
  output logic [CHANNEL_BITS-1:0]   dn_slo,
  output logic [CHANNEL_BITS-1:0]   dn_max,
  output logic                      dn_grey
);

  localparam int CB = CHANNEL_BITS;
  localparam int TW = CB + 3;
  localparam int NW = CB + 4;

  logic              red_max;
  logic              grn_max;
  logic [CB-1:0]     mx;
  logic [CB-1:0]     mn;
  logic [CB-1:0]     delta;
  logic [TW-1:0]     turn_nxt;
  logic [NW-1:0]     n_raw;
  logic [NW-1:0]     n_fix;
  logic [2*CB-1:0]   snum;

  logic              valid_r;
  logic [TW-1:0]     hrem_r;
  logic [TW-1:0]     turn_r;
  logic [CB-1:0]     srem_r;
  logic [CB-1:0]     slo_r;
  logic [CB-1:0]     max_r;
  logic              grey_r;

  always_comb begin
    red_max = (up_red >= up_green) && (up_red >= up_blue);
    grn_max = !red_max && (up_green >= up_blue);
    if (red_max) begin
      mx = up_red;
    end else if (grn_max) begin
      mx = up_green;
    end else begin
      mx = up_blue;
    end
    if ((up_red <= up_green) && (up_red <= up_blue)) begin
      mn = up_red;
    end else if (up_green <= up_blue) begin
      mn = up_green;
    end else begin
      mn = up_blue;
    end
    delta    = mx - mn;
    turn_nxt = TW'({delta, 2'b00}) + TW'({delta, 1'b0});
    // offset within the turn, before wrapping
    if (red_max) begin
      n_raw = NW'(up_green) - NW'(up_blue);
    end else if (grn_max) begin
      n_raw = NW'({delta, 1'b0}) + NW'(up_blue) - NW'(up_red);
    end else begin
      n_raw = NW'({delta, 2'b00}) + NW'(up_red) - NW'(up_green);
    end
    n_fix = n_raw[NW-1] ? (n_raw + NW'(turn_nxt)) : n_raw;
    snum  = {delta, {CB{1'b0}}} - (2*CB)'(delta);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      hrem_r <= n_fix[TW-1:0];
      turn_r <= turn_nxt;
      srem_r <= snum[2*CB-1:CB];
      slo_r  <= snum[CB-1:0];
      max_r  <= mx;
      grey_r <= (delta == '0);
    end
  end

  assign dn_valid = valid_r;
  assign dn_hrem  = hrem_r;
  assign dn_turn  = turn_r;
  assign dn_srem  = srem_r;
  assign dn_slo   = slo_r;
  assign dn_max   = max_r;
  assign dn_grey  = grey_r;

endmodule

/* rtl/core/rgbhsv_cell.sv */
// Divider cell: one restoring quotient bit for hue and for saturation per stage, as DO_HUE and DO_SAT enable.
`timescale 1ns / 1ps

module rgbhsv_cell
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = HUE_BITS_DEF,
  parameter bit DO_HUE       = 1'b1,
  parameter bit DO_SAT       = 1'b1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [CHANNEL_BITS+2:0]   up_hrem,
  input  logic [CHANNEL_BITS+2:0]   up_turn,
  input  logic [HUE_BITS-1:0]       up_hq,
  input  logic [CHANNEL_BITS-1:0]   up_srem,
  input  logic [CHANNEL_BITS-1:0]   up_slo,
  input  logic [CHANNEL_BITS-1:0]   up_max,
  input  logic [CHANNEL_BITS-1:0]   up_sq,
  input  logic                      up_grey,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [CHANNEL_BITS+2:0]   dn_hrem,
  output logic [CHANNEL_BITS+2:0]   dn_turn,
  output logic [HUE_BITS-1:0]       dn_hq,
  output logic [CHANNEL_BITS-1:0]   dn_srem,
  output logic [CHANNEL_BITS-1:0]   dn_slo,
  output logic [CHANNEL_BITS-1:0]   dn_max,
  output logic [CHANNEL_BITS-1:0]   dn_sq,
  output logic                      dn_grey
);

  localparam int CB = CHANNEL_BITS;
  localparam int HB = HUE_BITS;
  localparam int TW = CB + 3;

  logic [TW:0]       htrial;
  logic [TW:0]       hdiff;
  logic              hge;
  logic [CB:0]       strial;
  logic [CB:0]       sdiff;
  logic              sge;
  logic [TW-1:0]     hrem_nxt;
  logic [HB-1:0]     hq_nxt;
  logic [CB-1:0]     srem_nxt;
  logic [CB-1:0]     slo_nxt;
  logic [CB-1:0]     sq_nxt;

  logic              valid_r;
  logic [TW-1:0]     hrem_r;
  logic [TW-1:0]     turn_r;
  logic [HB-1:0]     hq_r;
  logic [CB-1:0]     srem_r;
  logic [CB-1:0]     slo_r;
  logic [CB-1:0]     max_r;
  logic [CB-1:0]     sq_r;
  logic              grey_r;

  always_comb begin
    htrial = {up_hrem, 1'b0};
    hge    = (htrial >= {1'b0, up_turn});
    hdiff  = htrial - {1'b0, up_turn};
    strial = {up_srem, up_slo[CB-1]};
    sge    = (strial >= {1'b0, up_max});
    sdiff  = strial - {1'b0, up_max};
    if (DO_HUE) begin
      hrem_nxt = hge ? hdiff[TW-1:0] : htrial[TW-1:0];
      hq_nxt   = {up_hq[HB-2:0], hge};
    end else begin
      hrem_nxt = up_hrem;
      hq_nxt   = up_hq;
    end
    if (DO_SAT) begin
      srem_nxt = sge ? sdiff[CB-1:0] : strial[CB-1:0];
      slo_nxt  = {up_slo[CB-2:0], 1'b0};
      sq_nxt   = {up_sq[CB-2:0], sge};
    end else begin
      srem_nxt = up_srem;
      slo_nxt  = up_slo;
      sq_nxt   = up_sq;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      hrem_r <= hrem_nxt;
      turn_r <= up_turn;
      hq_r   <= hq_nxt;
      srem_r <= srem_nxt;
      slo_r  <= slo_nxt;
      max_r  <= up_max;
      sq_r   <= sq_nxt;
      grey_r <= up_grey;
    end
  end

  assign dn_valid = valid_r;
  assign dn_hrem  = hrem_r;
  assign dn_turn  = turn_r;
  assign dn_hq    = hq_r;
  assign dn_srem  = srem_r;
  assign dn_slo   = slo_r;
  assign dn_max   = max_r;
  assign dn_sq    = sq_r;
  assign dn_grey  = grey_r;

endmodule

/* rtl/core/rgb_to_hsv_convert_core.sv */
// Throughput: one transaction per cycle while out_stall is low; a front stage, then a row of
// divider cells, each cell resolving one hue bit, one saturation bit or both.
// Every stage holds its data under a downstream stall and refills as soon as it empties.
// Reset (rst_n low, synchronous) empties the pipeline; no other state is kept.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_core
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = HUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CHANNEL_BITS-1:0]  in_red,
  input  logic [CHANNEL_BITS-1:0]  in_green,
  input  logic [CHANNEL_BITS-1:0]  in_blue,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [HUE_BITS-1:0]      out_hue,
  output logic [CHANNEL_BITS-1:0]  out_saturation,
  output logic [CHANNEL_BITS-1:0]  out_brightness
);

  localparam int CB    = CHANNEL_BITS;
  localparam int HB    = HUE_BITS;
  localparam int TW    = CB + 3;
  localparam int NSTEP = (HB > CB) ? HB : CB;

  logic              in_ready;
  logic              st_valid [0:NSTEP];
  logic              st_ready [0:NSTEP];
  logic [TW-1:0]     st_hrem  [0:NSTEP];
  logic [TW-1:0]     st_turn  [0:NSTEP];
  logic [HB-1:0]     st_hq    [0:NSTEP];
  logic [CB-1:0]     st_srem  [0:NSTEP];
  logic [CB-1:0]     st_slo   [0:NSTEP];
  logic [CB-1:0]     st_max   [0:NSTEP];
  logic [CB-1:0]     st_sq    [0:NSTEP];
  logic              st_grey  [0:NSTEP];

  rgbhsv_front #(
    .CHANNEL_BITS (CB)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_red   (in_red),
    .up_green (in_green),
    .up_blue  (in_blue),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_hrem  (st_hrem[0]),
    .dn_turn  (st_turn[0]),
    .dn_srem  (st_srem[0]),
    .dn_slo   (st_slo[0]),
    .dn_max   (st_max[0]),
    .dn_grey  (st_grey[0])
  );

  assign st_hq[0] = '0;
  assign st_sq[0] = '0;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    rgbhsv_cell #(
      .CHANNEL_BITS (CB),
      .HUE_BITS     (HB),
      .DO_HUE       (i >= NSTEP - HB),
      .DO_SAT       (i >= NSTEP - CB)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up_hrem  (st_hrem[i]),
      .up_turn  (st_turn[i]),
      .up_hq    (st_hq[i]),
      .up_srem  (st_srem[i]),
      .up_slo   (st_slo[i]),
      .up_max   (st_max[i]),
      .up_sq    (st_sq[i]),
      .up_grey  (st_grey[i]),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn_hrem  (st_hrem[i+1]),
      .dn_turn  (st_turn[i+1]),
      .dn_hq    (st_hq[i+1]),
      .dn_srem  (st_srem[i+1]),
      .dn_slo   (st_slo[i+1]),
      .dn_max   (st_max[i+1]),
      .dn_sq    (st_sq[i+1]),
      .dn_grey  (st_grey[i+1])
    );
  end

  assign st_ready[NSTEP] = !out_stall;
  assign in_stall        = !in_ready;

  // grey and black pixels: hue and saturation forced to zero
  assign out_valid      = st_valid[NSTEP];
  assign out_hue        = st_grey[NSTEP] ? '0 : st_hq[NSTEP];
  assign out_saturation = st_grey[NSTEP] ? '0 : st_sq[NSTEP];
  assign out_brightness = st_max[NSTEP];

endmodule

/* rtl/core/rgbhsv_checker.sv */
// Port-level checker for rgb_to_hsv_convert_core, with its bind.
`timescale 1ns / 1ps
`include "rgb_to_hsv_convert_core_assert.svh"

module rgbhsv_checker
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = HUE_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [CHANNEL_BITS-1:0]  in_red,
  input logic [CHANNEL_BITS-1:0]  in_green,
  input logic [CHANNEL_BITS-1:0]  in_blue,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [HUE_BITS-1:0]      out_hue,
  input logic [CHANNEL_BITS-1:0]  out_saturation,
  input logic [CHANNEL_BITS-1:0]  out_brightness
);

  logic unused_in;
  assign unused_in = in_valid ^ (^in_red) ^ (^in_green) ^ (^in_blue);

  `RGBHSV_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `RGBHSV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_hue) && $stable(out_saturation) && $stable(out_brightness), "stalled result changed")
  `RGBHSV_ASSERT(a_black, out_valid && out_brightness == 0 |-> out_saturation == 0 && out_hue == 0, "black pixel with colour")
  `RGBHSV_ASSERT(a_grey, out_valid && out_saturation == 0 |-> out_hue == 0, "grey pixel with hue")
  `RGBHSV_ASSERT(a_no_stall, !out_valid |-> !in_stall, "input stalled with empty output")

endmodule

bind rgb_to_hsv_convert_core rgbhsv_checker #(
  .CHANNEL_BITS (CHANNEL_BITS),
  .HUE_BITS     (HUE_BITS)
) u_rgbhsv_checker (.*);

/* bench/tb_rgb_to_hsv_convert_core.sv */
// Self-checking testbench for the pipelined RGB to HSV conversion core.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_convert_core;
  import rgbhsv_pkg::*;

  localparam int CB = CHANNEL_BITS_DEF;
  localparam int HB = HUE_BITS_DEF;
  localparam longint FULL = (longint'(1) << CB) - 1;
  localparam int DRAIN_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [HB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] bright;
  } hsv_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CB-1:0] in_red = '0;
  logic [CB-1:0] in_green = '0;
  logic [CB-1:0] in_blue = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [HB-1:0] out_hue;
  logic [CB-1:0] out_saturation;
  logic [CB-1:0] out_brightness;

  hsv_t pending_hsv[$];
  int   mismatch_count = 0;
  int   hold_cycles = 0;
  bit   idle_on = 1'b0;

  rgb_to_hsv_convert_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic hsv_t rgb_to_hsv(input logic [CB-1:0] r, g, b);
    longint rl, gl, bl;
    longint mx, mn, delta, base, diff, turn;
    hsv_t   res;
    rl = longint'(r);
    gl = longint'(g);
    bl = longint'(b);
    mx = rl;
    mn = rl;
    if (gl > mx) mx = gl;
    if (bl > mx) mx = bl;
    if (gl < mn) mn = gl;
    if (bl < mn) mn = bl;
    delta = mx - mn;
    res.hue = '0;
    res.sat = '0;
    res.bright = mx[CB-1:0];
    if (mx != 0 && delta != 0) begin
      res.sat = CB'((delta * FULL) / mx);
      if (rl == mx) begin
        base = 0;
        diff = gl - bl;
      end else if (gl == mx) begin
        base = 2;
        diff = bl - rl;
      end else begin
        base = 4;
        diff = rl - gl;
      end
      // one extra turn keeps the numerator positive; truncation to HB bits removes it
      turn = 6 * delta;
      res.hue = HB'(((base * delta + diff + turn) << HB) / turn);
    end
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hsv.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected transaction hue=%0d sat=%0d val=%0d", $time,
                   out_hue, out_saturation, out_brightness);
      end else begin
        want = pending_hsv.pop_front();
        if (out_hue !== want.hue || out_saturation !== want.sat ||
            out_brightness !== want.bright) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp hue=%0d sat=%0d val=%0d got hue=%0d sat=%0d val=%0d",
                     $time, want.hue, want.sat, want.bright,
                     out_hue, out_saturation, out_brightness);
        end
      end
    end
  end

  // result side stall, with optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send_pixel(input logic [CB-1:0] r, g, b);
    while (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hsv.push_back(rgb_to_hsv(r, g, b));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (pending_hsv.size() != 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %0d transactions never arrived", $time, pending_hsv.size());
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b0;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd10);
    send_pixel(8'd255, 8'd10, 8'd0);
    send_pixel(8'd10, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd10);
    send_pixel(8'd10, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd10, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd200, 8'd100, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd1);
    wait_drain();
  endtask

  task automatic send_random_pixel();
    logic [CB-1:0] r, g, b, lvl;
    int shape;
    shape = $urandom_range(9);
    r = CB'($urandom);
    g = CB'($urandom);
    b = CB'($urandom);
    lvl = CB'($urandom);
    case (shape)
      6: begin
        g = r;
        b = r;
      end
      7: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = r;
          default: b = g;
        endcase
      end
      8: begin
        r = lvl;
        g = (lvl > 2) ? lvl - CB'($urandom_range(2)) : lvl + CB'($urandom_range(2));
        b = (lvl > 2) ? lvl - CB'($urandom_range(2)) : lvl + CB'($urandom_range(2));
      end
      9: begin
        r = $urandom_range(1) ? CB'(FULL) : '0;
        g = $urandom_range(1) ? CB'(FULL) : '0;
        b = $urandom_range(1) ? CB'(FULL) : '0;
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  task automatic test_random_no_idle(input int n);
    idle_on = 1'b0;
    repeat (n) send_random_pixel();
    wait_drain();
  endtask

  task automatic test_random_with_idle(input int n);
    idle_on = 1'b1;
    repeat (n) send_random_pixel();
    idle_on = 1'b0;
    wait_drain();
  endtask

  task automatic test_backpressure(input int n);
    idle_on = 1'b0;
    hold_cycles = 150;
    repeat (n) send_random_pixel();
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_no_idle(250);
    test_backpressure(80);
    test_random_with_idle(1000);
    in_valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_hsv.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_front.sv
rtl/core/rgbhsv_cell.sv
rtl/core/rgb_to_hsv_convert_core.sv
rtl/core/rgbhsv_checker.sv
bench/tb_rgb_to_hsv_convert_core.sv
